>>> design/asob_pkg.sv
// ----------------------------------------------------------------------------
// asob_pkg: shared types and helpers for the source-over blend block
// Holds the transaction payload types, the queue item and pipeline stage
// types, and the rounded byte product used by both the front and back ends.
// ----------------------------------------------------------------------------
package asob_pkg;

   // Number of quotient bits produced by the channel divider.
   localparam int QUOT_BITS = 8;
   // Width of a channel numerator: dst_c*y + src_c*sa + total/2 < 2^17.
   localparam int NUM_W     = 17;
   // Number of color channels (B, G, R).
   localparam int CHANNELS  = 3;
   localparam logic [7:0] BYTE_MAX = 8'd255;

   // Input transaction payload.
   typedef struct packed {
      logic [31:0] dst_pixel;
      logic [31:0] src_pixel;
      logic        line_end;
   } asob_req_type;

   // Result transaction payload.
   typedef struct packed {
      logic [31:0] out_pixel;
      logic        out_line_end;
   } asob_rsp_type;

   // Classified item handed from the front end to the back end.
   typedef struct packed {
      logic [31:0] dst_pixel;
      logic [31:0] src_pixel;
      logic        line_end;
      logic [7:0]  sa;
      logic        pass;
   } asob_item_type;

   // Queue status seen by both ends.
   typedef struct packed {
      logic full;
      logic not_empty;
   } asob_qstat_type;

   // One stage of the back-end pipeline.
   typedef struct packed {
      logic                               valid;
      logic                               pass;
      logic                               line_end;
      logic [31:0]                        dst_pixel;
      logic [31:0]                        src_pixel;
      logic [7:0]                         sa;
      logic [7:0]                         y;
      logic [7:0]                         total;
      logic [CHANNELS-1:0][NUM_W-1:0]     rem;
      logic [CHANNELS-1:0][QUOT_BITS-1:0] quot;
   } asob_stage_type;

   // Rounded byte product: t = a*b + 128, result ((t >> 8) + t) >> 8.
   function automatic logic [7:0] scale_byte(input logic [7:0] a, input logic [7:0] b);
      logic [16:0] t;
      logic [16:0] u;
      t = 17'(a) * 17'(b) + 17'd128;
      u = t + (t >> 8);
      return u[15:8];
   endfunction

endpackage

>>> design/asob_front.sv
// ----------------------------------------------------------------------------
// asob_front: input stage of the source-over blend block
// Accepts pixel transactions, holds the opacity register, computes the
// effective source alpha and flags pixels whose source is invisible.
// ----------------------------------------------------------------------------
module asob_front
   import asob_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_stall,
   input  asob_req_type   req_data,
   input  logic           csr_wr_en,
   input  logic [7:0]     csr_wr_data,
   input  asob_qstat_type qstat,
   output logic           push,
   output asob_item_type  push_item
);

   logic          opacity_ff;
   logic [7:0]    opacity_val_ff;
   logic [7:0]    opacity_val_in;
   logic          hold_valid_ff;
   logic          hold_valid_in;
   asob_item_type hold_ff;
   asob_item_type hold_in;
   logic          accept;
   logic [7:0]    sa;

   // The holding register stalls the input only while the queue is full.
   assign req_stall = hold_valid_ff && qstat.full;
   assign accept    = req_valid && !req_stall;
   assign push      = hold_valid_ff && !qstat.full;
   assign push_item = hold_ff;

   // Opacity register, written by the configuration port.
   assign opacity_val_in = csr_wr_en ? csr_wr_data : opacity_val_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         opacity_ff     <= 1'b1;
         opacity_val_ff <= BYTE_MAX;
      end else begin
         opacity_ff     <= 1'b1;
         opacity_val_ff <= opacity_val_in;
      end
   end

   // Effective source alpha and classification of the incoming pixel.
   always_comb begin
      sa                = scale_byte(req_data.src_pixel[31:24], opacity_val_ff);
      hold_in           = hold_ff;
      hold_valid_in     = hold_valid_ff && qstat.full;
      if (accept) begin
         hold_in.dst_pixel = req_data.dst_pixel;
         hold_in.src_pixel = req_data.src_pixel;
         hold_in.line_end  = req_data.line_end;
         hold_in.sa        = sa;
         hold_in.pass      = (sa == 8'd0) || !opacity_ff;
         hold_valid_in     = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
      end else begin
         hold_valid_ff <= hold_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      hold_ff <= hold_in;
   end

endmodule

>>> design/asob_queue.sv
// ----------------------------------------------------------------------------
// asob_queue: decoupling queue between the front and back ends
// A small register FIFO of classified items so that each end can stall on
// its own.
// ----------------------------------------------------------------------------
module asob_queue
   import asob_pkg::*;
#(
   parameter int DEPTH = 4
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           push,
   input  asob_item_type  push_item,
   input  logic           pop,
   output asob_item_type  pop_item,
   output asob_qstat_type qstat
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   asob_item_type          mem_ff [DEPTH];
   logic [PTR_W-1:0]       wr_ptr_ff;
   logic [PTR_W-1:0]       wr_ptr_in;
   logic [PTR_W-1:0]       rd_ptr_ff;
   logic [PTR_W-1:0]       rd_ptr_in;
   logic [CNT_W-1:0]       count_ff;
   logic [CNT_W-1:0]       count_in;

   assign qstat.full      = (count_ff == CNT_W'(DEPTH));
   assign qstat.not_empty = (count_ff != '0);
   assign pop_item        = mem_ff[rd_ptr_ff];

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage write.
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

   // The front end never pushes into a full queue.
   assert property (@(posedge clock) disable iff (reset) push |-> !qstat.full)
      else $error("push into a full queue");

   // The back end never pops an empty queue.
   assert property (@(posedge clock) disable iff (reset) pop |-> qstat.not_empty)
      else $error("pop from an empty queue");

endmodule

>>> design/asob_back.sv
// ----------------------------------------------------------------------------
// asob_back: blend pipeline of the source-over blend block
// Computes the background weight and total alpha, forms the per-channel
// numerators, divides them by the total one quotient bit per stage and
// registers the result transaction.
// ----------------------------------------------------------------------------
module asob_back
   import asob_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  asob_qstat_type qstat,
   input  asob_item_type  pop_item,
   output logic           pop,
   output logic           rsp_valid,
   input  logic           rsp_stall,
   output asob_rsp_type   rsp_data
);

   // Stage 0 holds the popped item, stage 1 the weights, stage 2 the
   // numerators, then one stage per quotient bit.
   localparam int DIV_FIRST = 3;
   localparam int NSTG      = DIV_FIRST + QUOT_BITS;

   asob_stage_type st_ff [NSTG];
   asob_stage_type st_in [NSTG];
   logic           rsp_valid_ff;
   logic           rsp_valid_in;
   asob_rsp_type   rsp_ff;
   asob_rsp_type   rsp_in;
   logic           adv;

   // The whole pipeline moves whenever the output register can take a result.
   assign adv       = !rsp_valid_ff || !rsp_stall;
   assign pop       = adv && qstat.not_empty;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // Per-stage datapath.
   always_comb begin
      logic [8:0]       sum;
      logic [NUM_W-1:0] trial;
      int               b;

      // Stage 0: load from the queue.
      st_in[0]           = st_ff[0];
      st_in[0].valid     = qstat.not_empty;
      st_in[0].pass      = pop_item.pass;
      st_in[0].line_end  = pop_item.line_end;
      st_in[0].dst_pixel = pop_item.dst_pixel;
      st_in[0].src_pixel = pop_item.src_pixel;
      st_in[0].sa        = pop_item.sa;

      // Stage 1: background weight and total alpha (total never exceeds 255).
      st_in[1]       = st_ff[0];
      st_in[1].y     = scale_byte(st_ff[0].dst_pixel[31:24], BYTE_MAX - st_ff[0].sa);
      sum            = 9'(st_in[1].y) + 9'(st_ff[0].sa);
      st_in[1].total = sum[7:0];

      // Stage 2: rounded numerators, one lane per color channel.
      st_in[2] = st_ff[1];
      for (int c = 0; c < CHANNELS; c++) begin
         st_in[2].rem[c]  = NUM_W'(st_ff[1].dst_pixel[8*c +: 8]) * NUM_W'(st_ff[1].y)
                          + NUM_W'(st_ff[1].src_pixel[8*c +: 8]) * NUM_W'(st_ff[1].sa)
                          + NUM_W'(st_ff[1].total >> 1);
         st_in[2].quot[c] = '0;
      end

      // Division stages: restoring step for one quotient bit, MSB first.
      trial = '0;
      b     = 0;
      for (int k = 0; k < QUOT_BITS; k++) begin
         st_in[DIV_FIRST + k] = st_ff[DIV_FIRST + k - 1];
         b = QUOT_BITS - 1 - k;
         for (int c = 0; c < CHANNELS; c++) begin
            trial = NUM_W'(st_ff[DIV_FIRST + k - 1].total) << b;
            if (st_ff[DIV_FIRST + k - 1].rem[c] >= trial) begin
               st_in[DIV_FIRST + k].rem[c]     = st_ff[DIV_FIRST + k - 1].rem[c] - trial;
               st_in[DIV_FIRST + k].quot[c][b] = 1'b1;
            end
         end
      end

      // Output register: pass-through or the blended pixel.
      rsp_valid_in        = st_ff[NSTG-1].valid;
      rsp_in.out_line_end = st_ff[NSTG-1].line_end;
      if (st_ff[NSTG-1].pass) begin
         rsp_in.out_pixel = st_ff[NSTG-1].dst_pixel;
      end else begin
         rsp_in.out_pixel = {st_ff[NSTG-1].total, st_ff[NSTG-1].quot[2],
                             st_ff[NSTG-1].quot[1], st_ff[NSTG-1].quot[0]};
      end
   end

   // Stage registers; only the valid bits are reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < NSTG; s++) begin
            st_ff[s].valid <= 1'b0;
         end
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         for (int s = 0; s < NSTG; s++) begin
            st_ff[s].valid <= st_in[s].valid;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
      if (adv) begin
         for (int s = 0; s < NSTG; s++) begin
            st_ff[s].pass      <= st_in[s].pass;
            st_ff[s].line_end  <= st_in[s].line_end;
            st_ff[s].dst_pixel <= st_in[s].dst_pixel;
            st_ff[s].src_pixel <= st_in[s].src_pixel;
            st_ff[s].sa        <= st_in[s].sa;
            st_ff[s].y         <= st_in[s].y;
            st_ff[s].total     <= st_in[s].total;
            st_ff[s].rem       <= st_in[s].rem;
            st_ff[s].quot      <= st_in[s].quot;
         end
         rsp_ff <= rsp_in;
      end
   end

   // A blended pixel always has a nonzero total, so the divider is never
   // asked to divide by zero.
   assert property (@(posedge clock) disable iff (reset)
      st_ff[1].valid && !st_ff[1].pass |-> st_ff[1].total != 8'd0)
      else $error("blend with zero total alpha");

   // After the last quotient bit every remainder is below the divisor, which
   // means the quotient fit in a byte.
   assert property (@(posedge clock) disable iff (reset)
      st_ff[NSTG-1].valid && !st_ff[NSTG-1].pass |->
         (st_ff[NSTG-1].rem[0] < NUM_W'(st_ff[NSTG-1].total)) &&
         (st_ff[NSTG-1].rem[1] < NUM_W'(st_ff[NSTG-1].total)) &&
         (st_ff[NSTG-1].rem[2] < NUM_W'(st_ff[NSTG-1].total)))
      else $error("channel quotient overflowed a byte");

endmodule

>>> design/alpha_source_over_blend.sv
// ----------------------------------------------------------------------------
// alpha_source_over_blend: straight-alpha BGRA source-over compositor
// Top level: front end, decoupling queue and blend pipeline.
// ----------------------------------------------------------------------------
// The block takes one pixel transaction per clock and returns one result per
// clock when neither side stalls. From acceptance to result a pixel passes
// through the front end holding register, after the source alpha is scaled
// by the opacity register, then the queue, the stage that holds the popped
// item, the weight and numerator stages, the divider that produces one
// quotient bit per stage for all three color channels at once, and the
// output register. The queue of QUEUE_DEPTH items lets the input keep
// flowing for a while after the output stalls. The opacity register resets
// to 255 and is meant to be written only while no transaction is in flight.
// ----------------------------------------------------------------------------
module alpha_source_over_blend
   import asob_pkg::*;
#(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  asob_req_type req_data,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output asob_rsp_type rsp_data,
   input  logic         csr_wr_en,
   input  logic [7:0]   csr_wr_data
);

   asob_qstat_type qstat;
   logic           push;
   logic           pop;
   asob_item_type  push_item;
   asob_item_type  pop_item;

   // Front end: acceptance, opacity and classification.
   asob_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .qstat       (qstat),
      .push        (push),
      .push_item   (push_item)
   );

   // Decoupling queue.
   asob_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .pop_item  (pop_item),
      .qstat     (qstat)
   );

   // Back end: blend arithmetic and result register.
   asob_back u_back (
      .clock     (clock),
      .reset     (reset),
      .qstat     (qstat),
      .pop_item  (pop_item),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule
